// File: hdl/box_screen_scissor_rect_defines.svh
// ----------------------------------------------------------------------------
// Box screen scissor rect: assertion macros
// Shared concurrent checks; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOX_SCREEN_SCISSOR_RECT_DEFINES_SVH
`define BOX_SCREEN_SCISSOR_RECT_DEFINES_SVH
`ifndef SYNTHESIS
`define BSSR_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bssr check failed");
`define BSSR_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("bssr forbidden condition");
`else
`define BSSR_CHECK(label, prop)
`define BSSR_NEVER(label, expr)
`endif
`endif

// File: hdl/bssr_pkg.sv
// ----------------------------------------------------------------------------
// Box screen scissor rect: package
// Shared widths, constants, types and the final pixel conversion.
// ----------------------------------------------------------------------------
package bssr_pkg;
   localparam int CORNER_COUNT = 8;
   localparam int CNT_W        = $clog2(CORNER_COUNT);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int PROJ_W       = 35;          // px, py, pw after clipping
   localparam int SUM_W        = PROJ_W + 1;  // px + pw
   localparam int MUL_W        = SUM_W + 17;  // times viewport extent
   localparam int NUM_W        = MUL_W + 7;   // times 128
   localparam int DEN_W        = PROJ_W - 1;  // positive pw magnitude
   localparam int QMAG_W       = 31;          // quotient bits kept
   localparam int Q_W          = QMAG_W + 2;  // signed floored quotient
   localparam int POS_W        = Q_W + 1;     // Q8 screen position
   localparam int RECT_W       = 21;
   localparam logic signed [PROJ_W:0] CLIP_LIMIT = 36'sd17179869183;
   localparam logic signed [RECT_W-1:0] RECT_LIMIT = 21'sd999999;
   localparam logic signed [POS_W-1:0] INIT_Q8 = 34'sd255999744;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_ZERO  = 3'd0,
      CSR_AXIS_ONE   = 3'd1,
      CSR_AXIS_TWO   = 3'd2,
      CSR_PROJ_H     = 3'd3,
      CSR_PROJ_V     = 3'd4,
      CSR_PROJ_D     = 3'd5,
      CSR_VP_ORIGIN  = 3'd6,
      CSR_VP_SIZE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic first;
      logic last;
      logic front;
   } corner_tag_type;

   typedef struct packed {
      logic [2:0][47:0] axis;
      logic [31:0]      proj_h;
      logic [31:0]      proj_v;
      logic [31:0]      proj_d;
      logic [15:0]      vp_w;
      logic [15:0]      vp_h;
   } xform_cfg_type;

   // Q8 to pixel: truncate toward zero, then saturate
   function automatic logic signed [RECT_W-1:0] to_pixel(input logic signed [POS_W-1:0] v);
      logic signed [POS_W-1:0] t;
      t = (v < 0) ? ((v + POS_W'(255)) >>> 8) : (v >>> 8);
      if (t > POS_W'(RECT_LIMIT))
         return RECT_LIMIT;
      else if (t < -POS_W'(RECT_LIMIT))
         return -RECT_LIMIT;
      else
         return t[RECT_W-1:0];
   endfunction
endpackage

// File: hdl/bssr_req_if.sv
// ----------------------------------------------------------------------------
// Box screen scissor rect: request channel
// One box word: min and max corners.
// ----------------------------------------------------------------------------
interface bssr_req_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] min_x;
   logic signed [COORD_WIDTH-1:0] min_y;
   logic signed [COORD_WIDTH-1:0] min_z;
   logic signed [COORD_WIDTH-1:0] max_x;
   logic signed [COORD_WIDTH-1:0] max_y;
   logic signed [COORD_WIDTH-1:0] max_z;
   modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
   modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// File: hdl/bssr_rsp_if.sv
// ----------------------------------------------------------------------------
// Box screen scissor rect: response channel
// One rect word per box.
// ----------------------------------------------------------------------------
interface bssr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] rect_left;
   logic signed [20:0] rect_top;
   logic signed [20:0] rect_right;
   logic signed [20:0] rect_bottom;
   logic               none_in_front;
   modport source (output valid, rect_left, rect_top, rect_right, rect_bottom,
                   none_in_front, input ready);
   modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom,
                   none_in_front, output ready);
endinterface

// File: hdl/bssr_xform.sv
// ----------------------------------------------------------------------------
// Box screen scissor rect: corner transform
// Six stages: rotate, project, clip, form numerators and divisor.
// ----------------------------------------------------------------------------
module bssr_xform import bssr_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_v,
   input  corner_tag_type                in_tag,
   input  logic [2:0][COORD_WIDTH-1:0]   in_c,
   input  xform_cfg_type                 cfg,
   output logic                          out_v,
   output corner_tag_type                out_tag,
   output logic signed [1:0][NUM_W-1:0]  out_num,
   output logic [DEN_W-1:0]              out_den
);
   localparam int PRD_W = COORD_WIDTH + 16;
   localparam int VW    = COORD_WIDTH + 4;
   localparam int PP_W  = VW + 16;
   localparam int PS_W  = VW + 18;
   localparam int SH_W  = PS_W - 10;
   localparam int EW    = (SH_W > PROJ_W + 1) ? SH_W : PROJ_W + 1;

   logic [5:0]            v_ff;
   corner_tag_type        tag_ff [6];

   logic signed [PRD_W-1:0] prod_ff [3][3];
   logic signed [PRD_W-1:0] prod_in [3][3];
   logic signed [VW-1:0]    view_ff [3];
   logic signed [VW-1:0]    view_in [3];
   logic signed [PP_W-1:0]  pp_ff [5];
   logic signed [PP_W-1:0]  pp_in [5];
   logic signed [PROJ_W-1:0] clip_ff [3];
   logic signed [PROJ_W-1:0] clip_in [3];
   logic signed [SUM_W-1:0] sum_ff [2];
   logic signed [SUM_W-1:0] sum_in [2];
   logic [DEN_W-1:0]        den_ff, den5_ff;
   logic                    front_ff, front_in;
   logic signed [NUM_W-1:0] num_ff [2];
   logic signed [NUM_W-1:0] num_in [2];

   function automatic logic signed [PROJ_W-1:0] clip(input logic signed [EW-1:0] x);
      if (x > EW'(CLIP_LIMIT))
         return CLIP_LIMIT[PROJ_W-1:0];
      else if (x < -EW'(CLIP_LIMIT))
         return -CLIP_LIMIT[PROJ_W-1:0];
      else
         return x[PROJ_W-1:0];
   endfunction

   // rotate: nine coefficient products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[k][i] = PRD_W'($signed(in_c[i]) * $signed(cfg.axis[k][16*i +: 16]));
         end
      end
   end

   // sum rows, floor by 2^14
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         view_in[k] = VW'(((PRD_W+2)'(prod_ff[k][0]) + (PRD_W+2)'(prod_ff[k][1])
                         + (PRD_W+2)'(prod_ff[k][2])) >>> 14);
      end
   end

   // sparse projection products
   always_comb begin
      pp_in[0] = PP_W'(view_ff[0] * $signed(cfg.proj_h[15:0]));
      pp_in[1] = PP_W'(view_ff[2] * $signed(cfg.proj_h[31:16]));
      pp_in[2] = PP_W'(view_ff[1] * $signed(cfg.proj_v[15:0]));
      pp_in[3] = PP_W'(view_ff[2] * $signed(cfg.proj_v[31:16]));
      pp_in[4] = PP_W'(view_ff[2] * $signed(cfg.proj_d[15:0]));
   end

   // add terms, floor by 2^10, clip
   always_comb begin
      logic signed [PS_W-1:0] sx, sy, sw;
      logic signed [23:0]     p14;
      p14 = {cfg.proj_d[31:16], 8'b0};
      sx = PS_W'(pp_ff[0]) + PS_W'(pp_ff[1]);
      sy = PS_W'(pp_ff[2]) + PS_W'(pp_ff[3]);
      sw = PS_W'(pp_ff[4]) + PS_W'(p14);
      clip_in[0] = clip(EW'(SH_W'(sx >>> 10)));
      clip_in[1] = clip(EW'(SH_W'(sy >>> 10)));
      clip_in[2] = clip(EW'(SH_W'(sw >>> 10)));
   end

   // offsets by pw, mark corners in front
   always_comb begin
      sum_in[0] = SUM_W'(clip_ff[0]) + SUM_W'(clip_ff[2]);
      sum_in[1] = SUM_W'(clip_ff[1]) + SUM_W'(clip_ff[2]);
      front_in  = clip_ff[2] > 0;
   end

   // scale by viewport extent and 128
   always_comb begin
      num_in[0] = {MUL_W'(sum_ff[0] * $signed({1'b0, cfg.vp_w})), 7'b0};
      num_in[1] = {MUL_W'(sum_ff[1] * $signed({1'b0, cfg.vp_h})), 7'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_v};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= in_tag;
         for (int j = 1; j < 5; j++) tag_ff[j] <= tag_ff[j-1];
         tag_ff[5] <= {tag_ff[4].first, tag_ff[4].last, front_ff};
         prod_ff  <= prod_in;
         view_ff  <= view_in;
         pp_ff    <= pp_in;
         clip_ff  <= clip_in;
         sum_ff   <= sum_in;
         front_ff <= front_in;
         den_ff   <= clip_ff[2][DEN_W-1:0];
         den5_ff  <= den_ff;
         num_ff   <= num_in;
      end
   end

   assign out_v      = v_ff[5];
   assign out_tag    = tag_ff[5];
   assign out_num[0] = num_ff[0];
   assign out_num[1] = num_ff[1];
   assign out_den    = den5_ff;
endmodule

// File: hdl/bssr_div.sv
// ----------------------------------------------------------------------------
// Box screen scissor rect: floored divider
// Two lanes, shared divisor, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module bssr_div import bssr_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_v,
   input  corner_tag_type                in_tag,
   input  logic signed [1:0][NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]              in_den,
   output logic                          out_v,
   output corner_tag_type                out_tag,
   output logic signed [1:0][Q_W-1:0]    out_q
);
   localparam int R_W = DEN_W + 1;
   localparam int NS  = QMAG_W + 1;

   typedef struct packed {
      logic [R_W-1:0]    rem;
      logic [QMAG_W-1:0] low;
      logic [QMAG_W-1:0] quo;
      logic              neg;
      logic              ovf;
   } lane_type;

   logic [NUM_W-1:0]   mag_ff [2];
   logic [1:0]         neg_ff;
   lane_type           st_ff [NS][2];
   lane_type           st_in [NS][2];
   logic [DEN_W-1:0]   den_ff [NS];
   logic [NS+1:0]      v_ff;
   corner_tag_type     tag_ff [NS+2];
   logic signed [Q_W-1:0] q_ff [2];
   logic signed [Q_W-1:0] q_in [2];

   // first stage: split off high bits, detect quotient overflow
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         st_in[0][l].rem = R_W'(mag_ff[l][NUM_W-1:QMAG_W]);
         st_in[0][l].low = mag_ff[l][QMAG_W-1:0];
         st_in[0][l].quo = '0;
         st_in[0][l].neg = neg_ff[l];
         st_in[0][l].ovf = R_W'(mag_ff[l][NUM_W-1:QMAG_W]) >= {1'b0, den_ff[0]};
      end
      // restoring steps
      for (int k = 0; k < QMAG_W; k++) begin
         for (int l = 0; l < 2; l++) begin
            logic [R_W-1:0] t;
            logic           ge;
            t  = {st_ff[k][l].rem[R_W-2:0], st_ff[k][l].low[QMAG_W-1]};
            ge = t >= {1'b0, den_ff[k+1]};
            st_in[k+1][l].rem = ge ? (t - {1'b0, den_ff[k+1]}) : t;
            st_in[k+1][l].low = {st_ff[k][l].low[QMAG_W-2:0], 1'b0};
            st_in[k+1][l].quo = {st_ff[k][l].quo[QMAG_W-2:0], ge};
            st_in[k+1][l].neg = st_ff[k][l].neg;
            st_in[k+1][l].ovf = st_ff[k][l].ovf;
         end
      end
   end

   // floor toward minus infinity for negative numerators
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         logic [Q_W-1:0] qm;
         qm = st_ff[QMAG_W][l].ovf ? {2'b0, {QMAG_W{1'b1}}} : {2'b0, st_ff[QMAG_W][l].quo};
         if (st_ff[QMAG_W][l].neg)
            q_in[l] = -$signed(qm + Q_W'(st_ff[QMAG_W][l].rem != '0));
         else
            q_in[l] = $signed(qm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS:0], in_v};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            neg_ff[l] <= in_num[l][NUM_W-1];
            mag_ff[l] <= in_num[l][NUM_W-1] ? (~in_num[l] + 1'b1) : in_num[l];
         end
         den_ff[0] <= in_den;
         for (int k = 1; k < NS; k++) den_ff[k] <= den_ff[k-1];
         tag_ff[0] <= in_tag;
         for (int k = 1; k <= NS + 1; k++) tag_ff[k] <= tag_ff[k-1];
         st_ff <= st_in;
         q_ff  <= q_in;
      end
   end

   assign out_v    = v_ff[NS+1];
   assign out_tag  = tag_ff[NS+1];
   assign out_q[0] = q_ff[0];
   assign out_q[1] = q_ff[1];
endmodule

// File: hdl/box_screen_scissor_rect.sv
// ----------------------------------------------------------------------------
// Box screen scissor rect: top level
// Projects the eight corners of a box and forms its clamped screen rect.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  req_bus   in   valid/ready    min_x..max_z, signed Q15.8 box corners
//  rsp_bus   out  valid/ready    rect edges in pixels, none_in_front
//  csr_*     in   write enable   index 0..7, data up to 48 bits
//
//  The sequencer issues a box's eight corners, one per cycle unless frozen,
//  through a corner register and 43 further stages (6 transform, 34 divider,
//  position and accumulate, clamp, output register); a new box is taken on
//  the last corner of the previous one, so boxes follow without a gap.
//  Reset is synchronous and clears valid bits, sequencer and config registers.
//  A full output register with rsp_bus.ready low freezes every stage.
// ----------------------------------------------------------------------------
`include "box_screen_scissor_rect_defines.svh"
module box_screen_scissor_rect import bssr_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   bssr_req_if.sink                req_bus,
   bssr_rsp_if.source              rsp_bus,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);
   localparam logic [CNT_W-1:0] CORNER_LAST = CNT_W'(CORNER_COUNT - 1);

   // configuration registers
   logic [2:0][47:0] axis_ff;
   logic [31:0]      proj_h_ff, proj_v_ff, proj_d_ff, vp_org_ff, vp_size_ff;
   xform_cfg_type    cfg;

   // sequencer
   logic                         adv;
   logic                         accept;
   logic                         busy_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [5:0][COORD_WIDTH-1:0]  box_ff;
   logic                         cv_ff;
   corner_tag_type               ctag_ff;
   logic [2:0][COORD_WIDTH-1:0]  corner_ff;

   // transform and divider outputs
   logic                         xv;
   corner_tag_type               xtag;
   logic signed [1:0][NUM_W-1:0] xnum;
   logic [DEN_W-1:0]             xden;
   logic                         dv;
   corner_tag_type               dtag;
   logic signed [1:0][Q_W-1:0]   dq;

   // position, accumulate, result
   logic                         pv_ff;
   corner_tag_type               ptag_ff;
   logic signed [POS_W-1:0]      sx_ff, sy_ff;
   logic signed [POS_W-1:0]      mnx_ff, mny_ff, mxx_ff, mxy_ff;
   logic signed [POS_W-1:0]      mnx_in, mny_in, mxx_in, mxy_in;
   logic                         any_ff, any_in;
   logic                         res_v_ff;
   logic signed [POS_W-1:0]      rmnx_ff, rmny_ff, rmxx_ff, rmxy_ff;
   logic                         rany_ff;
   logic                         rsp_v_ff;
   logic signed [RECT_W-1:0]     left_ff, top_ff, right_ff, bottom_ff;
   logic signed [RECT_W-1:0]     left_in, top_in, right_in, bottom_in;
   logic                         nif_ff;

   // advance everything unless the output word is stuck
   assign adv    = !rsp_v_ff || rsp_bus.ready;
   assign req_bus.ready = adv && (!busy_ff || cnt_ff == CORNER_LAST);
   assign accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff    <= '0;
         proj_h_ff  <= '0;
         proj_v_ff  <= '0;
         proj_d_ff  <= '0;
         vp_org_ff  <= '0;
         vp_size_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_AXIS_ZERO: axis_ff[0] <= csr_wdata;
            CSR_AXIS_ONE:  axis_ff[1] <= csr_wdata;
            CSR_AXIS_TWO:  axis_ff[2] <= csr_wdata;
            CSR_PROJ_H:    proj_h_ff  <= csr_wdata[31:0];
            CSR_PROJ_V:    proj_v_ff  <= csr_wdata[31:0];
            CSR_PROJ_D:    proj_d_ff  <= csr_wdata[31:0];
            CSR_VP_ORIGIN: vp_org_ff  <= csr_wdata[31:0];
            CSR_VP_SIZE:   vp_size_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign cfg.axis   = axis_ff;
   assign cfg.proj_h = proj_h_ff;
   assign cfg.proj_v = proj_v_ff;
   assign cfg.proj_d = proj_d_ff;
   assign cfg.vp_w   = vp_size_ff[15:0];
   assign cfg.vp_h   = vp_size_ff[31:16];

   // hold the box, issue one corner per cycle while not frozen; corner bits pick max per axis
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         cv_ff   <= 1'b0;
      end else if (adv) begin
         cv_ff <= busy_ff;
         if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CORNER_LAST) busy_ff <= accept;
         end else if (accept) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (accept) begin
            box_ff <= {req_bus.max_z, req_bus.max_y, req_bus.max_x,
                       req_bus.min_z, req_bus.min_y, req_bus.min_x};
         end
         for (int i = 0; i < 3; i++) begin
            corner_ff[i] <= cnt_ff[i] ? box_ff[i+3] : box_ff[i];
         end
         ctag_ff.first <= cnt_ff == '0;
         ctag_ff.last  <= cnt_ff == CORNER_LAST;
         ctag_ff.front <= 1'b0;
      end
   end

   bssr_xform #(.COORD_WIDTH(COORD_WIDTH)) u_xform (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_v    (cv_ff),
      .in_tag  (ctag_ff),
      .in_c    (corner_ff),
      .cfg     (cfg),
      .out_v   (xv),
      .out_tag (xtag),
      .out_num (xnum),
      .out_den (xden)
   );

   bssr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_v    (xv),
      .in_tag  (xtag),
      .in_num  (xnum),
      .in_den  (xden),
      .out_v   (dv),
      .out_tag (dtag),
      .out_q   (dq)
   );

   // track min and max over corners in front; restart on a box's first corner
   always_comb begin
      logic signed [POS_W-1:0] bmnx, bmny, bmxx, bmxy;
      logic                    bany;
      bmnx = ptag_ff.first ? INIT_Q8  : mnx_ff;
      bmny = ptag_ff.first ? INIT_Q8  : mny_ff;
      bmxx = ptag_ff.first ? -INIT_Q8 : mxx_ff;
      bmxy = ptag_ff.first ? -INIT_Q8 : mxy_ff;
      bany = ptag_ff.first ? 1'b0 : any_ff;
      mnx_in = (ptag_ff.front && sx_ff < bmnx) ? sx_ff : bmnx;
      mny_in = (ptag_ff.front && sy_ff < bmny) ? sy_ff : bmny;
      mxx_in = (ptag_ff.front && sx_ff > bmxx) ? sx_ff : bmxx;
      mxy_in = (ptag_ff.front && sy_ff > bmxy) ? sy_ff : bmxy;
      any_in = bany || ptag_ff.front;
   end

   // clamp to the viewport, convert to pixels
   always_comb begin
      logic signed [POS_W-1:0] lox, loy, hix, hiy;
      lox = POS_W'({vp_org_ff[15:0], 8'b0});
      loy = POS_W'({vp_org_ff[31:16], 8'b0});
      hix = POS_W'({(17'(vp_org_ff[15:0]) + 17'(vp_size_ff[15:0])), 8'b0});
      hiy = POS_W'({(17'(vp_org_ff[31:16]) + 17'(vp_size_ff[31:16])), 8'b0});
      left_in   = to_pixel((rmnx_ff < lox) ? lox : rmnx_ff);
      top_in    = to_pixel((rmny_ff < loy) ? loy : rmny_ff);
      right_in  = to_pixel((rmxx_ff > hix) ? hix : rmxx_ff);
      bottom_in = to_pixel((rmxy_ff > hiy) ? hiy : rmxy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff    <= 1'b0;
         res_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         pv_ff    <= dv;
         res_v_ff <= pv_ff && ptag_ff.last;
         rsp_v_ff <= res_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ptag_ff <= dtag;
         sx_ff   <= POS_W'($signed(dq[0])) + POS_W'({vp_org_ff[15:0], 8'b0});
         sy_ff   <= POS_W'($signed(dq[1])) + POS_W'({vp_org_ff[31:16], 8'b0});
         if (pv_ff) begin
            mnx_ff <= mnx_in;
            mny_ff <= mny_in;
            mxx_ff <= mxx_in;
            mxy_ff <= mxy_in;
            any_ff <= any_in;
         end
         rmnx_ff   <= mnx_in;
         rmny_ff   <= mny_in;
         rmxx_ff   <= mxx_in;
         rmxy_ff   <= mxy_in;
         rany_ff   <= any_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         nif_ff    <= !rany_ff;
      end
   end

   assign rsp_bus.valid         = rsp_v_ff;
   assign rsp_bus.rect_left     = left_ff;
   assign rsp_bus.rect_top      = top_ff;
   assign rsp_bus.rect_right    = right_ff;
   assign rsp_bus.rect_bottom   = bottom_ff;
   assign rsp_bus.none_in_front = nif_ff;

   // a box enters only when the sequencer is free or on its last corner
   `BSSR_CHECK(a_accept_slot, accept |-> (!busy_ff || cnt_ff == CORNER_LAST))
   // a frozen pipeline keeps its sequencer
   `BSSR_CHECK(a_stall_hold, !adv |=> ($stable(cnt_ff) && $stable(busy_ff)))
   // nothing in front gives the empty rect
   `BSSR_CHECK(a_empty_rect, (rsp_v_ff && nif_ff) |-> (left_ff == RECT_LIMIT && right_ff == -RECT_LIMIT))
   // a result is formed only from a box's last corner
   `BSSR_NEVER(a_res_no_last, res_v_ff && $past(adv) && !$past(ptag_ff.last))
endmodule
